FILE: design/rtfl_pkg.sv
// ----------------------------------------------------------------------------
// rtfl_pkg
// Shared types and constants for the RGBA transfer function block.
// ----------------------------------------------------------------------------
package rtfl_pkg;

   localparam int MaxPoints = 16;
   localparam int KeyBits   = 16;
   localparam int IdxBits   = $clog2(MaxPoints);
   localparam int CntBits   = $clog2(MaxPoints + 1);
   localparam int ChanBits  = 16;
   localparam int FracBits  = 17;
   localparam int DivSteps  = 17;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusFull  = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

   localparam logic CmdInsert = 1'b0;
   localparam logic CmdSample = 1'b1;

   typedef struct packed {
      logic [ChanBits-1:0] red;
      logic [ChanBits-1:0] green;
      logic [ChanBits-1:0] blue;
      logic [ChanBits-1:0] alpha;
   } color_type;

   typedef struct packed {
      logic [KeyBits-1:0] key;
      color_type          color;
   } point_type;

   typedef struct packed {
      logic                cmd;
      logic [15:0]         in_key;
      logic [ChanBits-1:0] in_red;
      logic [ChanBits-1:0] in_green;
      logic [ChanBits-1:0] in_blue;
      logic [ChanBits-1:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [ChanBits-1:0] res_red;
      logic [ChanBits-1:0] res_green;
      logic [ChanBits-1:0] res_blue;
      logic [ChanBits-1:0] res_alpha;
      logic [1:0]          status;
      logic [15:0]         domain_low;
      logic [15:0]         domain_high;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic scan;      // compare one table entry
      logic shift;     // move one entry up during insert
      logic write;     // write new point at position
      logic grow;      // count++
      logic div_start;
      logic div_step;
      logic mix;       // select lo/hi operands and multiply
      logic finish;    // form response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_sample;
      logic empty;
      logic full;
      logic scan_done;
      logic shift_done;
      logic clamp;
      logic div_done;
   } stat_type;

endpackage

FILE: design/rtfl_stream_if.sv
// ----------------------------------------------------------------------------
// rtfl_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface rtfl_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/rtfl_ctrl.sv
// ----------------------------------------------------------------------------
// rtfl_ctrl
// Sequencer for insert and sample operations.
// ----------------------------------------------------------------------------
module rtfl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rtfl_pkg::stat_type  stat,
   output rtfl_pkg::cmd_type   cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StScan  = 3'd1;
   localparam logic [2:0] StShift = 3'd2;
   localparam logic [2:0] StDiv   = 3'd3;
   localparam logic [2:0] StMix   = 3'd4;
   localparam logic [2:0] StDone  = 3'd5;
   localparam logic [2:0] StOut   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StScan;
            end
         end
         StScan: begin
            if (!stat.is_sample && stat.full) begin
               state_in = StDone;
            end else if (stat.is_sample && (stat.empty || stat.clamp)) begin
               state_in = StDone;
            end else if (stat.scan_done) begin
               if (stat.is_sample) begin
                  cmd.div_start = 1'b1;
                  state_in = StDiv;
               end else begin
                  state_in = StShift;
               end
            end else begin
               cmd.scan = 1'b1;
            end
         end
         StShift: begin
            if (stat.shift_done) begin
               cmd.write = 1'b1;
               cmd.grow  = 1'b1;
               state_in  = StDone;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         StDiv: begin
            if (stat.div_done) begin
               state_in = StMix;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         StMix: begin
            cmd.mix  = 1'b1;
            state_in = StDone;
         end
         StDone: begin
            cmd.finish = 1'b1;
            state_in   = StOut;
         end
         StOut: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

endmodule

FILE: design/rtfl_datapath.sv
// ----------------------------------------------------------------------------
// rtfl_datapath
// Point table, scan, serial divider, channel mix and response register.
// ----------------------------------------------------------------------------
module rtfl_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rtfl_pkg::req_type   req,
   input  rtfl_pkg::cmd_type   cmd,
   output rtfl_pkg::stat_type  stat,
   output rtfl_pkg::rsp_type   rsp
);

   localparam int KB = rtfl_pkg::KeyBits;
   localparam int IB = rtfl_pkg::IdxBits;
   localparam int CB = rtfl_pkg::CntBits;
   localparam int FB = rtfl_pkg::FracBits;
   localparam int RB = KB + FB;

   rtfl_pkg::point_type table_ff [rtfl_pkg::MaxPoints];
   logic [CB-1:0]       count_ff;
   rtfl_pkg::req_type   req_ff;
   logic                drop_ff;
   logic [CB-1:0]       pos_ff;
   logic [CB-1:0]       shift_ff;
   logic [RB-1:0]       rem_ff;
   logic [KB-1:0]       den_ff;
   logic [FB-1:0]       quo_ff;
   logic [4:0]          step_ff;
   logic [36:0]         acc_ff [4];
   rtfl_pkg::rsp_type   rsp_ff, rsp_in;

   logic [KB-1:0] key;
   logic [KB-1:0] first_key, last_key;
   logic [IB-1:0] last_idx, pos_idx, lo_idx;
   logic          key_hit;
   logic [KB:0]   trial;

   assign key       = req_ff.in_key[KB-1:0];
   assign last_idx  = IB'(count_ff - CB'(1));
   assign pos_idx   = pos_ff[IB-1:0];
   assign lo_idx    = IB'(pos_ff - CB'(1));
   assign first_key = table_ff[0].key;
   assign last_key  = table_ff[last_idx].key;
   assign key_hit   = req_ff.cmd == rtfl_pkg::CmdSample ? table_ff[pos_idx].key >= key
                                                        : table_ff[pos_idx].key > key;
   assign trial     = rem_ff[RB-1:FB-1] - {1'b0, den_ff};

   always_comb begin
      stat.is_sample  = req_ff.cmd == rtfl_pkg::CmdSample;
      stat.empty      = count_ff == '0;
      stat.full       = count_ff == CB'(rtfl_pkg::MaxPoints);
      stat.scan_done  = pos_ff == count_ff || key_hit;
      stat.shift_done = shift_ff == pos_ff;
      stat.clamp      = key <= first_key || key >= last_key;
      stat.div_done   = step_ff == 5'(rtfl_pkg::DivSteps);
   end

   function automatic logic [36:0] mix_f(input logic [15:0] a, input logic [15:0] b,
                                         input logic [FB-1:0] t);
      logic [FB-1:0] u;
      begin
         u = FB'(65536) - t;
         mix_f = 37'(a) * 37'(u) + 37'(b) * 37'(t) + 37'd32768;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.grow) begin
         count_ff <= count_ff + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req;
         drop_ff  <= count_ff == CB'(rtfl_pkg::MaxPoints);
         pos_ff   <= '0;
      end else if (cmd.scan) begin
         pos_ff <= pos_ff + CB'(1);
      end
      if (cmd.load) begin
         shift_ff <= count_ff;
      end else if (cmd.shift) begin
         table_ff[shift_ff[IB-1:0]] <= table_ff[IB'(shift_ff - CB'(1))];
         shift_ff <= shift_ff - CB'(1);
      end
      if (cmd.write) begin
         table_ff[pos_idx] <= '{key: key,
                                color: '{red: req_ff.in_red, green: req_ff.in_green,
                                         blue: req_ff.in_blue, alpha: req_ff.in_alpha}};
      end
      if (cmd.div_start) begin
         rem_ff  <= {1'b0, key - table_ff[lo_idx].key, (FB-1)'(0)};
         den_ff  <= table_ff[pos_idx].key - table_ff[lo_idx].key;
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[KB]) begin
            rem_ff <= {trial[KB-1:0], rem_ff[FB-2:0], 1'b0};
         end else begin
            rem_ff <= {rem_ff[RB-2:0], 1'b0};
         end
         quo_ff  <= {quo_ff[FB-2:0], ~trial[KB]};
         step_ff <= step_ff + 5'd1;
      end
      if (cmd.mix) begin
         acc_ff[0] <= mix_f(table_ff[lo_idx].color.red, table_ff[pos_idx].color.red, quo_ff);
         acc_ff[1] <= mix_f(table_ff[lo_idx].color.green, table_ff[pos_idx].color.green,
                            quo_ff);
         acc_ff[2] <= mix_f(table_ff[lo_idx].color.blue, table_ff[pos_idx].color.blue, quo_ff);
         acc_ff[3] <= mix_f(table_ff[lo_idx].color.alpha, table_ff[pos_idx].color.alpha,
                            quo_ff);
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = rtfl_pkg::StatusOk;
      if (!stat.is_sample) begin
         if (drop_ff) begin
            rsp_in.status = rtfl_pkg::StatusFull;
         end
      end else if (stat.empty) begin
         rsp_in.status = rtfl_pkg::StatusEmpty;
      end else if (key <= first_key) begin
         rsp_in.res_red   = table_ff[0].color.red;
         rsp_in.res_green = table_ff[0].color.green;
         rsp_in.res_blue  = table_ff[0].color.blue;
         rsp_in.res_alpha = table_ff[0].color.alpha;
      end else if (key >= last_key) begin
         rsp_in.res_red   = table_ff[last_idx].color.red;
         rsp_in.res_green = table_ff[last_idx].color.green;
         rsp_in.res_blue  = table_ff[last_idx].color.blue;
         rsp_in.res_alpha = table_ff[last_idx].color.alpha;
      end else begin
         rsp_in.res_red   = acc_ff[0][31:16];
         rsp_in.res_green = acc_ff[1][31:16];
         rsp_in.res_blue  = acc_ff[2][31:16];
         rsp_in.res_alpha = acc_ff[3][31:16];
      end
      if (stat.empty) begin
         rsp_in.domain_low  = '0;
         rsp_in.domain_high = 16'({KB{1'b1}});
      end else begin
         rsp_in.domain_low  = 16'(first_key);
         rsp_in.domain_high = 16'(last_key);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

FILE: design/rgba_transfer_function_lerp.sv
// ----------------------------------------------------------------------------
// rgba_transfer_function_lerp
// Sorted RGBA control-point table with linear interpolation on sample.
// ----------------------------------------------------------------------------
// An insert's response waits on the table scan and on the shift of the points above
// its position; a dropped insert, empty or clamped sample skips both; an interpolated
// sample's response is set by the table scan and a 17-step restoring divide.
// Throughput: one beat in flight; next beat taken in the cycle after the response.
// Reset clears the point count and controller; table contents are not cleared.
module rgba_transfer_function_lerp (
   input  logic  clock,
   input  logic  reset,
   rtfl_stream_if.sink   req,
   rtfl_stream_if.source rsp
);

   rtfl_pkg::cmd_type  cmd;
   rtfl_pkg::stat_type stat;

   rtfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rtfl_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req.data),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp.data)
   );

endmodule

FILE: tb/rgba_transfer_function_lerp_tb.sv
// ----------------------------------------------------------------------------
// rgba_transfer_function_lerp_tb
// Self-checking bench: drives insert and sample beats with random idling on
// both channels, predicts each response from a local point table, and
// compares every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module rgba_transfer_function_lerp_tb;

   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtfl_stream_if #(.payload_type(rtfl_pkg::req_type)) req_ch ();
   rtfl_stream_if #(.payload_type(rtfl_pkg::rsp_type)) rsp_ch ();

   rgba_transfer_function_lerp dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted table
   logic [15:0]         tbl_key [rtfl_pkg::MaxPoints];
   rtfl_pkg::color_type tbl_col [rtfl_pkg::MaxPoints];
   int                  tbl_count;

   rtfl_pkg::rsp_type expected_rsps[$];
   int            error_count;
   int            rsp_seen;
   int            send_idle_pct;
   int            recv_idle_pct;
   bit            recv_hold;
   int            n_insert, n_sample, n_full, n_empty;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
   end

   function automatic logic [15:0] mix_chan(logic [15:0] a, logic [15:0] b,
                                            logic [16:0] t);
      logic [47:0] acc;
      acc = 48'(a) * (48'd65536 - 48'(t)) + 48'(b) * 48'(t) + 48'd32768;
      return acc[31:16];
   endfunction

   function automatic rtfl_pkg::rsp_type predict_rsp(rtfl_pkg::req_type r);
      rtfl_pkg::rsp_type o;
      int          pos, hi, lo;
      logic [32:0] span, t;
      o = '0;
      if (r.cmd == rtfl_pkg::CmdInsert) begin
         n_insert++;
         if (tbl_count >= rtfl_pkg::MaxPoints) begin
            o.status = rtfl_pkg::StatusFull;
            n_full++;
         end else begin
            pos = 0;
            while (pos < tbl_count && tbl_key[pos] <= r.in_key) pos++;
            for (int i = tbl_count; i > pos; i--) begin
               tbl_key[i] = tbl_key[i-1];
               tbl_col[i] = tbl_col[i-1];
            end
            tbl_key[pos] = r.in_key;
            tbl_col[pos] = '{r.in_red, r.in_green, r.in_blue, r.in_alpha};
            tbl_count++;
         end
      end else begin
         n_sample++;
         if (tbl_count == 0) begin
            o.status = rtfl_pkg::StatusEmpty;
            n_empty++;
         end else if (r.in_key <= tbl_key[0]) begin
            {o.res_red, o.res_green, o.res_blue, o.res_alpha} = tbl_col[0];
         end else if (r.in_key >= tbl_key[tbl_count-1]) begin
            {o.res_red, o.res_green, o.res_blue, o.res_alpha} = tbl_col[tbl_count-1];
         end else begin
            hi = 0;
            while (hi < tbl_count && tbl_key[hi] < r.in_key) hi++;
            lo = hi - 1;
            span = 33'(tbl_key[hi]) - 33'(tbl_key[lo]);
            t = 0;
            if (span != 0) t = ((33'(r.in_key) - 33'(tbl_key[lo])) << 16) / span;
            if (t > 65536) t = 65536;
            o.res_red   = mix_chan(tbl_col[lo].red,   tbl_col[hi].red,   t[16:0]);
            o.res_green = mix_chan(tbl_col[lo].green, tbl_col[hi].green, t[16:0]);
            o.res_blue  = mix_chan(tbl_col[lo].blue,  tbl_col[hi].blue,  t[16:0]);
            o.res_alpha = mix_chan(tbl_col[lo].alpha, tbl_col[hi].alpha, t[16:0]);
         end
      end
      if (tbl_count == 0) begin
         o.domain_low  = 16'd0;
         o.domain_high = 16'hFFFF;
      end else begin
         o.domain_low  = tbl_key[0];
         o.domain_high = tbl_key[tbl_count-1];
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: mismatch on %s: got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_beat(rtfl_pkg::req_type r);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsps.push_back(predict_rsp(r));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic rtfl_pkg::req_type make_beat(logic cmd, logic [15:0] key);
      rtfl_pkg::req_type r;
      r.cmd = cmd;
      r.in_key = key;
      r.in_red = 16'($urandom);
      r.in_green = 16'($urandom);
      r.in_blue = 16'($urandom);
      r.in_alpha = 16'($urandom);
      return r;
   endfunction

   // receiver ready
   always @(posedge clock) begin
      if (reset || recv_hold) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // response checker
   always @(posedge clock) begin
      rtfl_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: response beat with nothing expected", $realtime);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.data.res_red !== want.res_red)
               report_mismatch("res_red", rsp_ch.data.res_red, want.res_red);
            if (rsp_ch.data.res_green !== want.res_green)
               report_mismatch("res_green", rsp_ch.data.res_green, want.res_green);
            if (rsp_ch.data.res_blue !== want.res_blue)
               report_mismatch("res_blue", rsp_ch.data.res_blue, want.res_blue);
            if (rsp_ch.data.res_alpha !== want.res_alpha)
               report_mismatch("res_alpha", rsp_ch.data.res_alpha, want.res_alpha);
            if (rsp_ch.data.status !== want.status)
               report_mismatch("status", 16'(rsp_ch.data.status), 16'(want.status));
            if (rsp_ch.data.domain_low !== want.domain_low)
               report_mismatch("domain_low", rsp_ch.data.domain_low, want.domain_low);
            if (rsp_ch.data.domain_high !== want.domain_high)
               report_mismatch("domain_high", rsp_ch.data.domain_high, want.domain_high);
         end
      end
   end

   // table starts empty after reset and is not reset again between phases:
   // the table only grows, so once it fills, later phases run against a full table.
   task automatic test_directed();
      rtfl_pkg::req_type r;
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h0000));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'hFFFF));
      r = make_beat(rtfl_pkg::CmdInsert, 16'h1000);
      r.in_red = 16'h0000; r.in_green = 16'hFFFF; r.in_blue = 16'h0000; r.in_alpha = 16'hFFFF;
      send_beat(r);
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h0000));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h1000));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'hFFFF));
      r = make_beat(rtfl_pkg::CmdInsert, 16'h3000);
      r.in_red = 16'hFFFF; r.in_green = 16'h0000; r.in_blue = 16'hFFFF; r.in_alpha = 16'h0000;
      send_beat(r);
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h1001));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h2000));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h2FFF));
      send_beat(make_beat(rtfl_pkg::CmdInsert, 16'h3000));
      send_beat(make_beat(rtfl_pkg::CmdInsert, 16'h1000));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h3000));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h1000));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h1800));
      send_beat(make_beat(rtfl_pkg::CmdInsert, 16'h0000));
      send_beat(make_beat(rtfl_pkg::CmdInsert, 16'hFFFF));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'h0001));
      send_beat(make_beat(rtfl_pkg::CmdSample, 16'hFFFE));
      wait_drained();
   endtask

   task automatic test_random(int count);
      logic [15:0] k;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99, 0);
         if (sel < 10 && tbl_count < rtfl_pkg::MaxPoints)
            k = (tbl_count > 0 && $urandom_range(1, 0)) ?
                tbl_key[$urandom_range(tbl_count-1, 0)] : 16'($urandom);
         else if (sel < 60) begin
            if (tbl_count > 1 && $urandom_range(3, 0) != 0)
               k = tbl_key[0] + 16'($urandom_range(
                   tbl_key[tbl_count-1] - tbl_key[0], 0));
            else if (tbl_count > 0 && $urandom_range(1, 0))
               k = tbl_key[$urandom_range(tbl_count-1, 0)];
            else k = 16'($urandom);
            send_beat(make_beat(rtfl_pkg::CmdSample, k));
            continue;
         end else if (sel < 65) k = 16'($urandom);
         else begin
            send_beat(make_beat(rtfl_pkg::CmdSample, 16'($urandom)));
            continue;
         end
         send_beat(make_beat(rtfl_pkg::CmdInsert, k));
      end
   endtask

   task automatic test_fill_and_full();
      while (tbl_count < rtfl_pkg::MaxPoints)
         send_beat(make_beat(rtfl_pkg::CmdInsert, 16'($urandom)));
      for (int i = 0; i < 6; i++) send_beat(make_beat(rtfl_pkg::CmdInsert, 16'($urandom)));
      test_random(150);
   endtask

   task automatic test_backpressure();
      recv_hold = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 8; i++)
            send_beat(make_beat(rtfl_pkg::CmdSample, 16'($urandom)));
      join
      wait_drained();
   endtask

   initial begin
      error_count = 0; rsp_seen = 0; tbl_count = 0; recv_hold = 1'b0;
      n_insert = 0; n_sample = 0; n_full = 0; n_empty = 0;
      send_idle_pct = 26; recv_idle_pct = 79;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      wait_drained();
      send_idle_pct = 79; recv_idle_pct = 26;
      test_backpressure();
      test_fill_and_full();
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(350);
      wait_drained();
      $display("Covered %0d inserts (%0d dropped full) and %0d samples (%0d empty),",
               n_insert, n_full, n_sample, n_empty);
      $display("%0d response beats checked with %0d mismatches.", rsp_seen, error_count);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
